>>> design/ife_pkg.sv
// ife_pkg: shared types and constants for the ipv4 five-tuple extractor
// no dependencies
package ife_pkg;

  localparam int unsigned CounterWidthDefault = 48;
  localparam int unsigned CountOutWidth       = 48;

  localparam logic [15:0] EthLen      = 16'd14;
  localparam logic [15:0] MinIpHdr    = 16'd20;
  localparam logic [15:0] MinFrameLen = 16'd34;
  localparam logic [15:0] LenMax      = 16'hFFFF;
  localparam logic [15:0] TcpMin      = 16'd20;
  localparam logic [15:0] UdpMin      = 16'd8;
  localparam logic [15:0] TcpFlagsOfs = 16'd13;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [3:0]  Ipv4Version = 4'd4;

  // header field offsets from frame start
  localparam logic [15:0] OfsProtocol = EthLen + 16'd9;
  localparam logic [15:0] OfsSrcFirst = EthLen + 16'd12;
  localparam logic [15:0] OfsSrcLast  = EthLen + 16'd15;
  localparam logic [15:0] OfsDstFirst = EthLen + 16'd16;
  localparam logic [15:0] OfsDstLast  = EthLen + 16'd19;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_TOO_SHORT   = 2'd1,
    STATUS_NOT_IPV4    = 2'd2,
    STATUS_BAD_HDR_LEN = 2'd3
  } ife_status_e;

endpackage

>>> design/ipv4_five_tuple_extractor_top.sv
// ipv4_five_tuple_extractor_top: byte-stream ipv4/tcp/udp header parser with counters
// depends on ife_pkg
// result beat is registered: valid in the cycle after the beat carrying the last byte is accepted
// throughput: one byte per cycle while in_stall_o is low, set by the single capture stage feeding the result register
// a result waiting under stall holds off every input beat until it is taken
// reset: rst_ni asynchronous active low, clears frame state, counters and result valid
module ipv4_five_tuple_extractor_top
  import ife_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [31:0]              source_address_o,
  output logic [31:0]              destination_address_o,
  output logic [15:0]              source_port_o,
  output logic [15:0]              destination_port_o,
  output logic [7:0]               protocol_number_o,
  output logic [15:0]              frame_length_o,
  output logic [7:0]               flags_byte_o,
  output logic [CountOutWidth-1:0] frames_received_o,
  output logic [CountOutWidth-1:0] frames_processed_o,
  output logic [CountOutWidth-1:0] bytes_total_o
);

  logic [15:0] pos_q, pos_d;
  logic [7:0]  vlb_q, vlb_d;
  logic [7:0]  prot_q, prot_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] sp_q, sp_d;
  logic [15:0] dp_q, dp_d;
  logic [7:0]  flg_q, flg_d;

  logic [COUNTER_WIDTH-1:0] rcv_q, rcv_d;
  logic [COUNTER_WIDTH-1:0] proc_q, proc_d;
  logic [COUNTER_WIDTH-1:0] bytes_q, bytes_d;

  logic        out_valid_q, out_valid_d;
  ife_status_e status_q, status_d;
  logic [31:0] res_src_q, res_src_d;
  logic [31:0] res_dst_q, res_dst_d;
  logic [15:0] res_sp_q, res_sp_d;
  logic [15:0] res_dp_q, res_dp_d;
  logic [7:0]  res_prot_q, res_prot_d;
  logic [15:0] res_len_q, res_len_d;
  logic [7:0]  res_flg_q, res_flg_d;

  logic        in_acc;
  logic        last_acc;
  logic [15:0] tofs;
  logic [15:0] ihl;
  logic [15:0] ip_len;
  logic [15:0] tlen;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_acc   = in_acc && last_byte_i;

  // per-byte capture
  always_comb begin
    vlb_d  = vlb_q;
    prot_d = prot_q;
    src_d  = src_q;
    dst_d  = dst_q;
    sp_d   = sp_q;
    dp_d   = dp_q;
    flg_d  = flg_q;
    tofs   = EthLen + {10'd0, vlb_q[3:0], 2'b00};
    if (pos_q == EthLen) begin
      vlb_d = data_byte_i;
    end
    if (pos_q == OfsProtocol) begin
      prot_d = data_byte_i;
    end
    if (pos_q >= OfsSrcFirst && pos_q <= OfsSrcLast) begin
      src_d = {src_q[23:0], data_byte_i};
    end
    if (pos_q >= OfsDstFirst && pos_q <= OfsDstLast) begin
      dst_d = {dst_q[23:0], data_byte_i};
    end
    if (pos_q > EthLen) begin
      if (pos_q == tofs) begin
        sp_d = {data_byte_i, 8'd0};
      end
      if (pos_q == tofs + 16'd1) begin
        sp_d = {sp_q[15:8], data_byte_i};
      end
      if (pos_q == tofs + 16'd2) begin
        dp_d = {data_byte_i, 8'd0};
      end
      if (pos_q == tofs + 16'd3) begin
        dp_d = {dp_q[15:8], data_byte_i};
      end
      if (pos_q == tofs + TcpFlagsOfs) begin
        flg_d = data_byte_i;
      end
    end
    pos_d = (pos_q < LenMax) ? pos_q + 16'd1 : LenMax;
  end

  // frame verdict on the last byte
  always_comb begin
    ihl        = {10'd0, vlb_d[3:0], 2'b00};
    ip_len     = pos_d - EthLen;
    tlen       = ip_len - ihl;
    status_d   = STATUS_OK;
    res_src_d  = '0;
    res_dst_d  = '0;
    res_sp_d   = '0;
    res_dp_d   = '0;
    res_prot_d = '0;
    res_flg_d  = '0;
    res_len_d  = pos_d;
    rcv_d      = rcv_q;
    proc_d     = proc_q;
    bytes_d    = bytes_q;
    if (pos_d < MinFrameLen) begin
      status_d = STATUS_TOO_SHORT;
    end else begin
      rcv_d   = rcv_q + COUNTER_WIDTH'(1);
      bytes_d = bytes_q + COUNTER_WIDTH'(pos_d);
      if (vlb_d[7:4] != Ipv4Version) begin
        status_d = STATUS_NOT_IPV4;
      end else if (ihl < MinIpHdr || ip_len < ihl) begin
        status_d = STATUS_BAD_HDR_LEN;
      end else begin
        status_d   = STATUS_OK;
        res_src_d  = src_d;
        res_dst_d  = dst_d;
        res_prot_d = prot_d;
        proc_d     = proc_q + COUNTER_WIDTH'(1);
        if (prot_d == ProtoTcp && tlen >= TcpMin) begin
          res_sp_d  = sp_d;
          res_dp_d  = dp_d;
          res_flg_d = flg_d;
        end else if (prot_d == ProtoUdp && tlen >= UdpMin) begin
          res_sp_d = sp_d;
          res_dp_d = dp_d;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (last_acc) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      vlb_q       <= '0;
      prot_q      <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      sp_q        <= '0;
      dp_q        <= '0;
      flg_q       <= '0;
      rcv_q       <= '0;
      proc_q      <= '0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (last_acc) begin
        pos_q   <= '0;
        vlb_q   <= '0;
        prot_q  <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        sp_q    <= '0;
        dp_q    <= '0;
        flg_q   <= '0;
        rcv_q   <= rcv_d;
        proc_q  <= proc_d;
        bytes_q <= bytes_d;
      end else if (in_acc) begin
        pos_q  <= pos_d;
        vlb_q  <= vlb_d;
        prot_q <= prot_d;
        src_q  <= src_d;
        dst_q  <= dst_d;
        sp_q   <= sp_d;
        dp_q   <= dp_d;
        flg_q  <= flg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_acc) begin
      status_q   <= status_d;
      res_src_q  <= res_src_d;
      res_dst_q  <= res_dst_d;
      res_sp_q   <= res_sp_d;
      res_dp_q   <= res_dp_d;
      res_prot_q <= res_prot_d;
      res_len_q  <= res_len_d;
      res_flg_q  <= res_flg_d;
    end
  end

  // counters only move when a new result loads, so they track the held beat
  assign out_valid_o           = out_valid_q;
  assign status_o              = status_q;
  assign source_address_o      = res_src_q;
  assign destination_address_o = res_dst_q;
  assign source_port_o         = res_sp_q;
  assign destination_port_o    = res_dp_q;
  assign protocol_number_o     = res_prot_q;
  assign frame_length_o        = res_len_q;
  assign flags_byte_o          = res_flg_q;
  assign frames_received_o     = CountOutWidth'(64'(rcv_q));
  assign frames_processed_o    = CountOutWidth'(64'(proc_q));
  assign bytes_total_o         = CountOutWidth'(64'(bytes_q));

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> out_valid_q)
    else $error("last byte accepted without a result beat");

  a_last_clears_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> (pos_q == '0 && vlb_q == '0))
    else $error("frame state not cleared after last byte");

  a_bad_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STATUS_OK) |->
      (res_src_q == '0 && res_dst_q == '0 && res_sp_q == '0 && res_flg_q == '0))
    else $error("tuple fields nonzero on a failed frame");

  a_short_not_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_acc && pos_d < MinFrameLen) |=> $stable(rcv_q) && $stable(bytes_q))
    else $error("short frame was counted");
`endif

endmodule
